// ----- rtl/core/hufd_pkg.sv -----
// hufd_pkg: shared types, constants and helpers for the huffman tree byte decoder
// used by hufd_walk_engine, hufd_out_stage, huffman_tree_byte_decoder_top
// and by the verification files; no dependencies
package hufd_pkg;

  // node table geometry
  localparam int TREE_NODES = 512;
  localparam int NODE_AW    = $clog2(TREE_NODES);

  // field widths fixed by the item format
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 48;
  localparam int OP_W    = 2;
  localparam int BIT_CW  = $clog2(BYTE_W + 1);

  // stream widths
  localparam int IN_FIELDS_W = IDX_W + 1 + SYM_W + 2 * IDX_W + BYTE_W + COUNT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = SYM_W;

  // item kinds carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_START      = 2'd1,
    OP_DATA       = 2'd2
  } op_e;

  // walk sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } walk_state_e;

  // one node table entry
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // one input item, unpacked
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   node_index;
    node_t              node;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] symbol_count;
  } item_t;

  // symbol event from the walk engine to the output stage
  typedef struct packed {
    logic             emit;
    logic             flush;
    logic [SYM_W-1:0] symbol;
    logic             done;
  } emit_t;

  // index lies inside the table
  function automatic logic idx_in_range(logic [IDX_W-1:0] idx);
    return 32'(idx) < TREE_NODES;
  endfunction

  // table address from a node index
  function automatic logic [NODE_AW-1:0] node_addr(logic [IDX_W-1:0] idx);
    logic [IDX_W+NODE_AW-1:0] wide;
    wide = {{NODE_AW{1'b0}}, idx};
    return wide[NODE_AW-1:0];
  endfunction

endpackage

// ----- rtl/core/hufd_walk_engine.sv -----
// hufd_walk_engine: node table memory and the bit-serial tree walk sequencer
// depends on hufd_pkg
// at most one child fetch per bit, current and root entries kept in registers
module hufd_walk_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  hufd_pkg::item_t item_i,
  input  logic          go_i,
  output hufd_pkg::emit_t emit_o
);
  import hufd_pkg::*;

  // node table, undefined until written
  node_t mem_q [TREE_NODES];

  walk_state_e        state_q, state_d;
  logic [IDX_W-1:0]   cur_node_q, cur_node_d;
  node_t              cur_ent_q, cur_ent_d;
  node_t              root_q, root_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [BIT_CW-1:0]  bits_q, bits_d;
  logic [COUNT_W-1:0] remain_q, remain_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   child_q, child_d;
  node_t              rdata_q;

  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  logic               rd_en;
  logic [NODE_AW-1:0] rd_addr;
  node_t              ent_cur;
  node_t              proc_ent;
  logic               do_proc;
  logic [IDX_W-1:0]   next_child;

  assign ent_cur    = (cur_node_q == '0) ? root_q : cur_ent_q;
  assign mem_waddr  = node_addr(item_i.node_index);

  // sequencer: item decode in idle, bit steps while running and go_i is high; no item is taken while running
  always_comb begin
    state_d    = state_q;
    cur_node_d = cur_node_q;
    cur_ent_d  = cur_ent_q;
    root_d     = root_q;
    byte_d     = byte_q;
    bits_d     = bits_q;
    remain_d   = remain_q;
    pend_d     = pend_q;
    child_d    = child_q;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    emit_o     = '0;
    item_ready_o = 1'b0;
    do_proc    = 1'b0;
    proc_ent   = ent_cur;
    next_child = '0;

    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          case (op_e'(item_i.opcode))
            OP_WRITE_NODE: begin
              if (idx_in_range(item_i.node_index)) begin
                mem_we = 1'b1;
                if (item_i.node_index == '0) root_d = item_i.node;
                if (item_i.node_index == cur_node_q) cur_ent_d = item_i.node;
              end
            end
            OP_START: begin
              cur_node_d = '0;
              remain_d   = item_i.symbol_count;
            end
            OP_DATA: begin
              byte_d  = item_i.data_byte;
              bits_d  = BIT_CW'(BYTE_W);
              pend_d  = 1'b0;
              state_d = ST_RUN;
            end
            default: ;
          endcase
        end
      end

      ST_RUN: begin
        if (go_i) begin
          if (pend_q) begin
            // child fetch came back
            if (rdata_q.leaf) begin
              emit_o.emit   = 1'b1;
              emit_o.symbol = rdata_q.symbol;
              emit_o.done   = (remain_q == COUNT_W'(1));
              remain_d      = remain_q - COUNT_W'(1);
              cur_node_d    = '0;
              pend_d        = 1'b0;
            end else begin
              cur_node_d = child_q;
              cur_ent_d  = rdata_q;
              pend_d     = 1'b0;
              proc_ent   = rdata_q;
              do_proc    = (bits_q != '0) && (remain_q != '0);
            end
          end else if ((bits_q != '0) && (remain_q != '0)) begin
            do_proc = 1'b1;
          end else begin
            // byte finished or count exhausted
            emit_o.flush = 1'b1;
            state_d      = ST_IDLE;
          end

          // consume one bit from the current entry
          if (do_proc) begin
            byte_d = {byte_q[BYTE_W-2:0], 1'b0};
            bits_d = bits_q - BIT_CW'(1);
            if (proc_ent.leaf) begin
              emit_o.emit   = 1'b1;
              emit_o.symbol = proc_ent.symbol;
              emit_o.done   = (remain_q == COUNT_W'(1));
              remain_d      = remain_q - COUNT_W'(1);
              cur_node_d    = '0;
            end else begin
              next_child = byte_q[BYTE_W-1] ? proc_ent.left : proc_ent.right;
              if (!idx_in_range(next_child)) begin
                cur_node_d = '0;
              end else begin
                rd_en   = 1'b1;
                rd_addr = node_addr(next_child);
                child_d = next_child;
                pend_d  = 1'b1;
              end
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_node_q <= '0;
      remain_q   <= '0;
      bits_q     <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_node_q <= cur_node_d;
      remain_q   <= remain_d;
      bits_q     <= bits_d;
      pend_q     <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_ent_q <= cur_ent_d;
    root_q    <= root_d;
    byte_q    <= byte_d;
    child_q   <= child_d;
  end

  // node table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= item_i.node;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

endmodule

// ----- rtl/core/hufd_out_stage.sv -----
// hufd_out_stage: holds one decoded symbol until the next tells whether it ends the byte
// depends on hufd_pkg
// feeds a registered output beat, stalls the walk when both are full and tready is low
module hufd_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hufd_pkg::emit_t                emit_i,
  output logic                           go_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hufd_pkg::SYM_W-1:0]     m_axis_tdata_sym_o,
  output logic                           m_axis_tlast,
  output logic                           m_axis_done_o
);
  import hufd_pkg::*;

  logic             hold_valid_q, hold_valid_d;
  logic [SYM_W-1:0] hold_sym_q;
  logic             hold_done_q;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;
  logic             out_done_q;
  logic             out_free;
  logic             push;
  logic             push_last;

  assign out_free = !out_valid_q || m_axis_tready;
  assign go_o     = !hold_valid_q || out_free;

  // a held symbol moves out when a newer one arrives or the byte ends
  always_comb begin
    push         = hold_valid_q && (emit_i.emit || emit_i.flush);
    push_last    = emit_i.flush;
    hold_valid_d = hold_valid_q;
    if (emit_i.emit) begin
      hold_valid_d = 1'b1;
    end else if (emit_i.flush) begin
      hold_valid_d = 1'b0;
    end
    out_valid_d = push ? 1'b1 : (out_valid_q && !m_axis_tready);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (emit_i.emit) begin
      hold_sym_q  <= emit_i.symbol;
      hold_done_q <= emit_i.done;
    end
    if (push) begin
      out_sym_q  <= hold_sym_q;
      out_done_q <= hold_done_q;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid      = out_valid_q;
  assign m_axis_tdata_sym_o = out_sym_q;
  assign m_axis_tlast       = out_last_q;
  assign m_axis_done_o      = out_done_q;

endmodule

// ----- rtl/core/huffman_tree_byte_decoder_top.sv -----
// huffman_tree_byte_decoder_top: stream wrapper of the huffman tree byte decoder
// depends on hufd_pkg, hufd_walk_engine, hufd_out_stage
// node write, start and unused beats are taken in idle; a data byte is accepted and walked
// with one step per bit (an extra step when the child read turns up a leaf), one more when
// the last bit fetched an inner node, and one to close the byte; no new beat is taken till
// then; a symbol leaves once the next symbol or the end of its byte is known; output stalls
// hold the walk only when both stages are full; reset clears the walk position, symbol count
// and all valid flags; the node table is not cleared and must be written before it is walked
module huffman_tree_byte_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: node_index[8:0], node_is_leaf[9], node_symbol[17:10], node_left[26:18],
  //        node_right[35:27], data_byte[43:36], symbol_count[91:44], zero [95:92]
  input  logic [hufd_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [hufd_pkg::OP_W-1:0]      s_axis_tuser,
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: symbol[7:0]
  output logic [hufd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: last symbol of this data byte
  output logic                           m_axis_tlast,
  // tuser: stream_done[0]
  output logic                           m_axis_tuser
);
  import hufd_pkg::*;

  item_t item;
  emit_t emit;
  logic  go;

  // unpack the input beat
  assign item.opcode       = s_axis_tuser;
  assign item.node_index   = s_axis_tdata[8:0];
  assign item.node.leaf    = s_axis_tdata[9];
  assign item.node.symbol  = s_axis_tdata[17:10];
  assign item.node.left    = s_axis_tdata[26:18];
  assign item.node.right   = s_axis_tdata[35:27];
  assign item.data_byte    = s_axis_tdata[43:36];
  assign item.symbol_count = s_axis_tdata[91:44];

  hufd_walk_engine u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (item),
    .go_i        (go),
    .emit_o      (emit)
  );

  hufd_out_stage u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .emit_i            (emit),
    .go_o              (go),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata_sym_o(m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .m_axis_done_o     (m_axis_tuser)
  );

endmodule

// ----- verif/hufd_checker.sv -----
// hufd_checker: watches both streams of the huffman tree byte decoder, predicts the symbols
// each data byte yields and compares them beat by beat with the master side
// depends on hufd_pkg
`timescale 1ns / 100ps

module hufd_checker
  import hufd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata: node_index, node_is_leaf, node_symbol, node_left, node_right, data_byte,
  //        symbol_count, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode
  input  logic [OP_W-1:0]       s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: symbol
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  // tuser: stream_done
  input  logic                  m_axis_tuser,
  output int                    errors_o,
  output int                    pending_o
);

  // one decoded symbol as it should leave the block
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } decoded_t;

  // shadow copy of the tree and the walk
  node_t              node_mem [TREE_NODES];
  logic [IDX_W-1:0]   walk_pos;
  logic [COUNT_W-1:0] symbols_left;
  decoded_t           expected_symbols [$];
  decoded_t           oldest;
  int                 error_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // walk one coded byte msb first and queue every symbol it yields
  task automatic walk_byte(input logic [BYTE_W-1:0] code);
    decoded_t         batch [BYTE_W];
    node_t            entry;
    logic [IDX_W-1:0] child;
    logic             hit;
    int               count;
    count = 0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (symbols_left != '0) begin
        hit   = 1'b0;
        entry = node_mem[walk_pos];
        if (entry.leaf) begin
          // walk sits on a leaf: emit it for this bit
          hit = 1'b1;
        end else begin
          child = code[b] ? entry.left : entry.right;
          if (32'(child) >= TREE_NODES) begin
            walk_pos = '0;
          end else begin
            entry = node_mem[child];
            if (entry.leaf) hit = 1'b1;
            else walk_pos = child;
          end
        end
        if (hit) begin
          walk_pos      = '0;
          symbols_left  = symbols_left - 1'b1;
          batch[count]  = '{symbol: entry.symbol, last: 1'b0, done: (symbols_left == '0)};
          count++;
        end
      end
    end
    for (int k = 0; k < count; k++) begin
      if (k == count - 1) batch[k].last = 1'b1;
      expected_symbols.push_back(batch[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_pos     = '0;
      symbols_left = '0;
      expected_symbols.delete();
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      // input beat: update the shadow state
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_WRITE_NODE: begin
            if (32'(s_axis_tdata[8:0]) < TREE_NODES) begin
              node_mem[s_axis_tdata[8:0]] = '{leaf: s_axis_tdata[9],
                                              symbol: s_axis_tdata[17:10],
                                              left: s_axis_tdata[26:18],
                                              right: s_axis_tdata[35:27]};
            end
          end
          OP_START: begin
            walk_pos     = '0;
            symbols_left = s_axis_tdata[91:44];
          end
          OP_DATA: walk_byte(s_axis_tdata[43:36]);
          default: ;
        endcase
      end
      // output beat: compare with the oldest expected symbol
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch($sformatf("symbol %02h with nothing expected", m_axis_tdata));
        end else begin
          oldest = expected_symbols.pop_front();
          if (m_axis_tdata !== oldest.symbol)
            report_mismatch($sformatf("symbol %02h, want %02h", m_axis_tdata, oldest.symbol));
          if (m_axis_tlast !== oldest.last)
            report_mismatch($sformatf("tlast %b, want %b on symbol %02h",
                                      m_axis_tlast, oldest.last, oldest.symbol));
          if (m_axis_tuser !== oldest.done)
            report_mismatch($sformatf("stream_done %b, want %b on symbol %02h",
                                      m_axis_tuser, oldest.done, oldest.symbol));
        end
      end
      pending_o <= expected_symbols.size();
      errors_o  <= error_count;
    end
  end

endmodule

// ----- verif/tb_huffman_tree_byte_decoder_top.sv -----
// tb_huffman_tree_byte_decoder_top: builds code trees, starts streams and feeds coded bytes
// into the decoder under random idling on both sides, then reports the verdict
// depends on hufd_pkg, hufd_checker and huffman_tree_byte_decoder_top
`timescale 1ns / 100ps

module tb_huffman_tree_byte_decoder_top;
  import hufd_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED    = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam int                 CYCLE_LIMIT  = 400000;
  localparam int                 DRAIN_CYCLES = 40;
  localparam int                 RANDOM_ITEMS = 150;
  localparam int                 PAD_W        = IN_DATA_W - IN_FIELDS_W;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  int               mismatches;
  int               pending;
  int               send_idle_pct = 8;
  int               recv_idle_pct = 58;
  int               items_sent    = 0;
  int               cycle_count   = 0;
  bit               written [TREE_NODES];
  logic [IDX_W-1:0] written_q [$];

  huffman_tree_byte_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  hufd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (mismatches),
    .pending_o     (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("huffman_tree_byte_decoder_top test failed");
      $finish;
    end
  end

  function automatic logic [COUNT_W-1:0] rand_count();
    return COUNT_W'({$urandom(), $urandom()});
  endfunction

  // any entry already written, so the walk never reaches an unwritten one
  function automatic logic [IDX_W-1:0] rand_written();
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  // one input beat, with a random gap in front; valid stays up for the next beat
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic leaf, input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right,
                           input logic [BYTE_W-1:0] code, input logic [COUNT_W-1:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {PAD_W'(0), count, code, right, left, sym, leaf, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, input logic leaf,
                            input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] left,
                            input logic [IDX_W-1:0] right);
    send_item(OP_WRITE_NODE, idx, leaf, sym, left, right, BYTE_W'($urandom()), rand_count());
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_q.push_back(idx);
    end
  endtask

  task automatic start_stream(input logic [COUNT_W-1:0] count);
    send_item(OP_START, IDX_W'($urandom()), 1'($urandom()), SYM_W'($urandom()),
              IDX_W'($urandom()), IDX_W'($urandom()), BYTE_W'($urandom()), count);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] code);
    send_item(OP_DATA, IDX_W'($urandom()), 1'($urandom()), SYM_W'($urandom()),
              IDX_W'($urandom()), IDX_W'($urandom()), code, rand_count());
  endtask

  task automatic send_unused();
    send_item(OP_UNUSED, IDX_W'($urandom()), 1'($urandom()), SYM_W'($urandom()),
              IDX_W'($urandom()), IDX_W'($urandom()), BYTE_W'($urandom()), rand_count());
  endtask

  // random full tree rooted at entry 0: split random leaves until the count is reached
  task automatic build_tree(input int leaves);
    bit               taken [TREE_NODES];
    bit               inner [TREE_NODES];
    logic [IDX_W-1:0] kid_l [TREE_NODES];
    logic [IDX_W-1:0] kid_r [TREE_NODES];
    logic [IDX_W-1:0] slot [$];
    logic [IDX_W-1:0] kids [2];
    logic [IDX_W-1:0] pos;
    int               choice;
    int               pick;
    taken    = '{default: 1'b0};
    inner    = '{default: 1'b0};
    taken[0] = 1'b1;
    slot.push_back('0);
    repeat (leaves - 1) begin
      choice = $urandom_range(0, slot.size() - 1);
      pos    = slot[choice];
      slot.delete(choice);
      for (int k = 0; k < 2; k++) begin
        do pick = $urandom_range(1, TREE_NODES - 1); while (taken[pick]);
        taken[pick] = 1'b1;
        kids[k]     = IDX_W'(pick);
        slot.push_back(IDX_W'(pick));
      end
      kid_l[pos] = kids[0];
      kid_r[pos] = kids[1];
      inner[pos] = 1'b1;
    end
    // highest index first, root last
    for (int i = TREE_NODES - 1; i >= 0; i--) begin
      if (taken[i]) begin
        if (inner[i]) write_node(IDX_W'(i), 1'b0, SYM_W'($urandom()), kid_l[i], kid_r[i]);
        else write_node(IDX_W'(i), 1'b1, SYM_W'($urandom()), IDX_W'($urandom()),
                        IDX_W'($urandom()));
      end
    end
  endtask

  // mostly trees, starts and coded bytes, with rewrites and unused items as noise
  task automatic run_random(input int quota);
    int                 stop_at;
    int                 roll;
    logic [COUNT_W-1:0] count;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        build_tree($urandom_range(1, 12));
        start_stream(COUNT_W'($urandom_range(1, 40)));
      end else if (roll < 18) begin
        case ($urandom_range(0, 9))
          0:       count = '0;
          1:       count = COUNT_MAX;
          2:       count = rand_count();
          default: count = COUNT_W'($urandom_range(1, 40));
        endcase
        start_stream(count);
      end else if (roll < 24) begin
        // rewrite a live entry, possibly under the walk
        if ($urandom_range(0, 1))
          write_node(rand_written(), 1'b1, SYM_W'($urandom()), IDX_W'($urandom()),
                     IDX_W'($urandom()));
        else
          write_node(rand_written(), 1'b0, SYM_W'($urandom()), rand_written(),
                     rand_written());
      end else if (roll < 27) begin
        send_unused();
      end else begin
        send_byte(BYTE_W'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // root that is a leaf yields its symbol on every bit
    write_node('0, 1'b1, 8'hFF, '1, '1);
    start_stream(COUNT_W'(3));
    send_byte(8'h00);
    // count used up: nothing more
    send_byte(8'hFF);
    send_unused();
    // start with zero count
    start_stream('0);
    send_byte(8'hA5);

    // two level tree: 1 -> 0x00, 0 then 1 -> 0x7f, 0 then 0 -> 0x80
    write_node(IDX_W'(3), 1'b1, 8'h7F, IDX_W'($urandom()), IDX_W'($urandom()));
    write_node(IDX_W'(4), 1'b1, 8'h80, IDX_W'($urandom()), IDX_W'($urandom()));
    write_node(IDX_W'(1), 1'b1, 8'h00, IDX_W'($urandom()), IDX_W'($urandom()));
    write_node(IDX_W'(2), 1'b0, SYM_W'($urandom()), IDX_W'(3), IDX_W'(4));
    write_node('0, 1'b0, SYM_W'($urandom()), IDX_W'(1), IDX_W'(2));
    start_stream(COUNT_MAX);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    // walk now parked on entry 2: turn it into a leaf under the walk
    write_node(IDX_W'(2), 1'b1, 8'h3C, IDX_W'($urandom()), IDX_W'($urandom()));
    send_byte(8'h80);
    write_node(IDX_W'(2), 1'b0, SYM_W'($urandom()), IDX_W'(3), IDX_W'(4));
    // count runs out in the middle of a byte
    start_stream(COUNT_W'(2));
    send_byte(8'h00);

    // random part over three idling settings
    run_random(RANDOM_ITEMS / 3);
    send_idle_pct = 58;
    recv_idle_pct = 8;
    run_random(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    s_axis_tvalid <= 1'b0;

    // drain and let the last byte finish
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("huffman_tree_byte_decoder_top test passed");
    end else begin
      $display("huffman_tree_byte_decoder_top test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hufd_pkg.sv
rtl/core/hufd_walk_engine.sv
rtl/core/hufd_out_stage.sv
rtl/core/huffman_tree_byte_decoder_top.sv
verif/hufd_checker.sv
verif/tb_huffman_tree_byte_decoder_top.sv
